[rtl/rcq_pkg.sv]
package rcq_pkg;

    // Field widths fixed by the interface
    localparam int COEF_W  = 16;
    localparam int RECIP_W = 16;
    localparam int CORR_W  = 16;
    localparam int SHIFT_W = 4;
    localparam int INDEX_W = 6;
    localparam int PROD_W  = RECIP_W + CORR_W;
    localparam int SH_W    = 5;

    // Operation codes
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_QUANTIZE = 1'b1;

    // Base shift applied after the multiply
    localparam logic [SH_W-1:0] BASE_SHIFT = SH_W'(16);

    // One divisor table entry
    typedef struct packed {
        logic [RECIP_W-1:0] reciprocal;
        logic [CORR_W-1:0]  correction;
        logic [SHIFT_W-1:0] extra_shift;
    } entry_t;

    // Quantize beat handed from the table read stage to the arithmetic
    typedef struct packed {
        entry_t             entry;
        logic [COEF_W-1:0]  coefficient;
        logic               last;
    } quant_req_t;

endpackage

[rtl/rcq_table.sv]
module rcq_table
    import rcq_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/rcq_arith.sv]
module rcq_arith
    import rcq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  quant_req_t         req,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COEF_W-1:0]  out_value,
    output logic               out_last
);

    // Stage A: magnitude plus correction
    logic               a_valid_reg;
    logic [CORR_W-1:0]  a_sum_reg;
    logic [RECIP_W-1:0] a_recip_reg;
    logic [SHIFT_W-1:0] a_shift_reg;
    logic               a_neg_reg;
    logic               a_last_reg;

    // Stage B: product
    logic               b_valid_reg;
    logic [PROD_W-1:0]  b_prod_reg;
    logic [SHIFT_W-1:0] b_shift_reg;
    logic               b_neg_reg;
    logic               b_last_reg;

    // Output register
    logic               o_valid_reg;
    logic [COEF_W-1:0]  o_value_reg;
    logic               o_last_reg;

    logic               o_free;
    logic               b_ready;
    logic               a_ready;

    logic               neg;
    logic [COEF_W-1:0]  mag;
    logic [CORR_W-1:0]  sum_next;
    logic [PROD_W-1:0]  prod_next;
    logic [SH_W-1:0]    sh;
    logic [COEF_W-1:0]  shifted;
    logic [COEF_W-1:0]  value_next;

    // Backpressure chain: a stage moves when the one after it frees up
    assign o_free  = !o_valid_reg || out_ready;
    assign b_ready = !b_valid_reg || o_free;
    assign a_ready = !a_valid_reg || b_ready;
    assign req_ready = a_ready;

    // Magnitude (most negative value wraps to 0x8000) and rounding add
    assign neg      = req.coefficient[COEF_W-1];
    assign mag      = neg ? (COEF_W'(0) - req.coefficient) : req.coefficient;
    assign sum_next = mag + req.entry.correction;

    // 16x16 multiply
    assign prod_next = PROD_W'(a_sum_reg) * PROD_W'(a_recip_reg);

    // Shift by 16 plus extra, keep low bits, restore sign
    assign sh         = BASE_SHIFT + SH_W'(b_shift_reg);
    assign shifted    = COEF_W'(b_prod_reg >> sh);
    assign value_next = b_neg_reg ? (COEF_W'(0) - shifted) : shifted;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= req_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (o_free)
            begin
                o_valid_reg <= b_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (a_ready && req_valid)
        begin
            a_sum_reg   <= sum_next;
            a_recip_reg <= req.entry.reciprocal;
            a_shift_reg <= req.entry.extra_shift;
            a_neg_reg   <= neg;
            a_last_reg  <= req.last;
        end
        if (b_ready && a_valid_reg)
        begin
            b_prod_reg  <= prod_next;
            b_shift_reg <= a_shift_reg;
            b_neg_reg   <= a_neg_reg;
            b_last_reg  <= a_last_reg;
        end
        if (o_free && b_valid_reg)
        begin
            o_value_reg <= value_next;
            o_last_reg  <= b_last_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_value = o_value_reg;
    assign out_last  = o_last_reg;

endmodule

[rtl/reciprocal_coefficient_quantizer.sv]
// Reciprocal coefficient quantizer. Each input beat is either a load, which
// writes reciprocal, rounding correction and extra shift for one table
// position (index taken modulo BLOCK_COEFFS) and returns nothing, or a
// quantize, which takes the coefficient at the internal block position,
// returns (|c| + corr) * recip >> (16 + extra_shift), sign restored and
// wrapped to 16 bits, and flags the last position of the block. One beat is
// accepted per cycle while in_ready is high, loads and quantizes mixed freely;
// a quantize result passes in order through the registered table read, the
// correction add, the registered multiply and the output register. A
// quantize may follow a load of the same position in the next cycle.
// Entries must be loaded before use.
module reciprocal_coefficient_quantizer
    import rcq_pkg::*;
#(
    parameter int BLOCK_COEFFS = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      operation,
    input  logic [INDEX_W-1:0]        table_index,
    input  logic signed [COEF_W-1:0]  coefficient,
    input  logic [RECIP_W-1:0]        reciprocal,
    input  logic [CORR_W-1:0]         correction,
    input  logic [SHIFT_W-1:0]        extra_shift,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COEF_W-1:0]  quantized_value,
    output logic                      last_in_block
);

    localparam int POS_W = $clog2(BLOCK_COEFFS);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_COEFFS - 1);

    logic               accept;
    logic               load_beat;
    logic               quant_beat;
    logic [INDEX_W-1:0] idx_mod;
    logic [POS_W-1:0]   wr_addr;
    entry_t             wr_entry;
    entry_t             rd_entry;

    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;

    logic               s1_valid_reg;
    logic [COEF_W-1:0]  s1_coef_reg;
    logic               s1_last_reg;
    logic               s1_ready;
    quant_req_t         req;
    logic [COEF_W-1:0]  out_value;

    // Input handshake
    assign in_ready   = !s1_valid_reg || s1_ready;
    assign accept     = in_valid && in_ready;
    assign load_beat  = accept && (operation == OP_LOAD);
    assign quant_beat = accept && (operation == OP_QUANTIZE);

    // Table index modulo block size: a 6-bit index needs at most 3 subtracts when BLOCK_COEFFS >= 16
    always_comb
    begin
        idx_mod = table_index;
        for (int i = 0; i < 3; i++)
        begin
            if (int'(idx_mod) >= BLOCK_COEFFS)
            begin
                idx_mod = idx_mod - INDEX_W'(BLOCK_COEFFS);
            end
        end
    end

    assign wr_addr              = POS_W'(idx_mod);
    assign wr_entry.reciprocal  = reciprocal;
    assign wr_entry.correction  = correction;
    assign wr_entry.extra_shift = extra_shift;

    // Divisor table, read at the block position on each quantize beat
    rcq_table #(
        .DEPTH  (BLOCK_COEFFS),
        .ADDR_W (POS_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (load_beat),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (quant_beat),
        .rd_addr (pos_reg),
        .rd_data (rd_entry)
    );

    // Block position counter
    assign pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + POS_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (quant_beat)
            begin
                pos_reg <= pos_next;
            end
            if (in_ready)
            begin
                s1_valid_reg <= quant_beat;
            end
        end
    end

    // Coefficient and last flag travel beside the table read
    always_ff @(posedge clk)
    begin
        if (quant_beat)
        begin
            s1_coef_reg <= coefficient;
            s1_last_reg <= (pos_reg == LAST_POS);
        end
    end

    assign req.entry       = rd_entry;
    assign req.coefficient = s1_coef_reg;
    assign req.last        = s1_last_reg;

    rcq_arith u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s1_valid_reg),
        .req_ready (s1_ready),
        .req       (req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_value (out_value),
        .out_last  (last_in_block)
    );

    assign quantized_value = out_value;

endmodule

[sim/quantizer_checker.sv]
`timescale 1ns / 1ps

module quantizer_checker
    import rcq_pkg::*;
#(
    parameter int BLOCK_COEFFS = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic                      operation,
    input  logic [INDEX_W-1:0]        table_index,
    input  logic signed [COEF_W-1:0]  coefficient,
    input  logic [RECIP_W-1:0]        reciprocal,
    input  logic [CORR_W-1:0]         correction,
    input  logic [SHIFT_W-1:0]        extra_shift,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic signed [COEF_W-1:0]  quantized_value,
    input  logic                      last_in_block,
    output int                        error_count,
    output int                        outstanding
);

    typedef struct packed {
        logic [COEF_W-1:0] value;
        logic              last;
    } quant_result_t;

    // Shadow divisor tables and block position
    logic [RECIP_W-1:0] recip_tbl [BLOCK_COEFFS];
    logic [CORR_W-1:0]  corr_tbl  [BLOCK_COEFFS];
    logic [SHIFT_W-1:0] shift_tbl [BLOCK_COEFFS];
    int                 block_pos;

    quant_result_t      quant_expected [$];
    quant_result_t      oldest;
    int                 mismatches;

    // (|c| + corr) * recip >> (16 + shift), sign put back, all mod 2^16
    function automatic logic [COEF_W-1:0] quantize_coef(
        logic [COEF_W-1:0]  coef,
        logic [RECIP_W-1:0] recip,
        logic [CORR_W-1:0]  corr,
        logic [SHIFT_W-1:0] shift
    );
        logic              neg;
        logic [COEF_W-1:0] mag;
        logic [COEF_W-1:0] sum;
        logic [31:0]       prod;
        logic [4:0]        sh;
        logic [COEF_W-1:0] res;
        neg  = coef[COEF_W-1];
        mag  = neg ? -coef : coef;
        sum  = mag + corr;
        prod = {16'd0, sum} * {16'd0, recip};
        sh   = {1'b0, shift} + 5'd16;
        res  = COEF_W'(prod >> sh);
        if (neg)
            res = -res;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_pos = 0;
            mismatches = 0;
            quant_expected.delete();
            error_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            // result beat: compare with the oldest expectation
            if (out_valid && out_ready)
            begin
                if (quant_expected.size() == 0)
                begin
                    $error("unexpected result: quantized_value %0d last_in_block %0d",
                           quantized_value, last_in_block);
                    mismatches++;
                end
                else
                begin
                    oldest = quant_expected.pop_front();
                    if (quantized_value !== oldest.value)
                    begin
                        $error("quantized_value: expected %0d, actual %0d",
                               $signed(oldest.value), quantized_value);
                        mismatches++;
                    end
                    if (last_in_block !== oldest.last)
                    begin
                        $error("last_in_block: expected %0d, actual %0d",
                               oldest.last, last_in_block);
                        mismatches++;
                    end
                end
            end

            // input beat: update tables or queue the expected result
            if (in_valid && in_ready)
            begin
                if (operation == OP_LOAD)
                begin
                    recip_tbl[int'(table_index) % BLOCK_COEFFS] = reciprocal;
                    corr_tbl[int'(table_index) % BLOCK_COEFFS]  = correction;
                    shift_tbl[int'(table_index) % BLOCK_COEFFS] = extra_shift;
                end
                else
                begin
                    quant_expected.push_back('{
                        value: quantize_coef(coefficient, recip_tbl[block_pos],
                                             corr_tbl[block_pos], shift_tbl[block_pos]),
                        last:  (block_pos == BLOCK_COEFFS - 1)
                    });
                    block_pos = (block_pos + 1) % BLOCK_COEFFS;
                end
            end

            error_count <= mismatches;
            outstanding <= quant_expected.size();
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import rcq_pkg::*;

    localparam int BLOCK_COEFFS   = 64;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 10;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      operation;
    logic [INDEX_W-1:0]        table_index;
    logic signed [COEF_W-1:0]  coefficient;
    logic [RECIP_W-1:0]        reciprocal;
    logic [CORR_W-1:0]         correction;
    logic [SHIFT_W-1:0]        extra_shift;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [COEF_W-1:0]  quantized_value;
    logic                      last_in_block;
    int                        error_count;
    int                        outstanding;

    // stimulus knobs and bookkeeping
    int                        send_idle_pct;
    int                        recv_stall_pct;
    logic                      hold_pending;
    logic                      hold_done;
    logic [BLOCK_COEFFS-1:0]   loaded;
    int                        stim_pos;
    int                        idle_cycles;

    reciprocal_coefficient_quantizer #(.BLOCK_COEFFS(BLOCK_COEFFS)) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .table_index     (table_index),
        .coefficient     (coefficient),
        .reciprocal      (reciprocal),
        .correction      (correction),
        .extra_shift     (extra_shift),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .quantized_value (quantized_value),
        .last_in_block   (last_in_block)
    );

    quantizer_checker #(.BLOCK_COEFFS(BLOCK_COEFFS)) quant_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .table_index     (table_index),
        .coefficient     (coefficient),
        .reciprocal      (reciprocal),
        .correction      (correction),
        .extra_shift     (extra_shift),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .quantized_value (quantized_value),
        .last_in_block   (last_in_block),
        .error_count     (error_count),
        .outstanding     (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_pending && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: ends the run when no beat moves for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("testbench failed");
        $finish;
    end

    function automatic logic [COEF_W-1:0] pick_coefficient();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return COEF_W'($urandom_range(2)) - 16'd1;
            3, 4, 5: return COEF_W'($urandom_range(511)) - 16'd256;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // One input beat, with a random gap in front of it
    task automatic send_beat(
        logic               op,
        logic [INDEX_W-1:0] idx,
        logic [COEF_W-1:0]  coef,
        logic [RECIP_W-1:0] recip,
        logic [CORR_W-1:0]  corr,
        logic [SHIFT_W-1:0] shift
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        table_index <= idx;
        coefficient <= coef;
        reciprocal  <= recip;
        correction  <= corr;
        extra_shift <= shift;
        do
            @(posedge clk);
        while (!in_ready);
        if (op == OP_LOAD)
            loaded[idx] = 1'b1;
        else
            stim_pos = (stim_pos + 1) % BLOCK_COEFFS;
    endtask

    // Mostly quantizes; a position never loaded gets its load first
    task automatic send_random_item();
        logic [INDEX_W-1:0] idx;
        if (!loaded[stim_pos] || $urandom_range(99) < 15)
        begin
            idx = loaded[stim_pos] ? INDEX_W'($urandom_range(63)) : INDEX_W'(stim_pos);
            send_beat(OP_LOAD, idx, pick_coefficient(), RECIP_W'($urandom),
                      ($urandom_range(3) == 0) ? CORR_W'($urandom_range(255))
                                               : CORR_W'($urandom),
                      SHIFT_W'($urandom_range(15)));
        end
        else
        begin
            send_beat(OP_QUANTIZE, INDEX_W'($urandom), pick_coefficient(),
                      RECIP_W'($urandom), CORR_W'($urandom), SHIFT_W'($urandom));
        end
    endtask

    task automatic run_phase(int count, int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) send_random_item();
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        operation      = OP_LOAD;
        table_index    = '0;
        coefficient    = '0;
        reciprocal     = '0;
        correction     = '0;
        extra_shift    = '0;
        hold_pending   = 1'b0;
        loaded         = '0;
        stim_pos       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: table extremes, sign extremes, wrapping sum and result
        send_beat(OP_LOAD,     6'd0,  16'h1234, 16'hFFFF, 16'h0000, 4'h0);
        send_beat(OP_LOAD,     6'd1,  16'h0000, 16'hFFFF, 16'hFFFF, 4'h0);
        send_beat(OP_LOAD,     6'd2,  16'hFFFF, 16'h0000, 16'h0000, 4'hF);
        send_beat(OP_LOAD,     6'd3,  16'h0000, 16'h0001, 16'h0001, 4'hF);
        send_beat(OP_LOAD,     6'd4,  16'h0000, 16'h8000, 16'h7FFF, 4'h7);
        send_beat(OP_LOAD,     6'd63, 16'h0000, 16'h5555, 16'hAAAA, 4'hA);
        send_beat(OP_QUANTIZE, 6'd63, 16'h8000, 16'hFFFF, 16'hFFFF, 4'hF);
        send_beat(OP_QUANTIZE, 6'd0,  16'h7FFF, 16'h0000, 16'h0000, 4'h0);
        send_beat(OP_QUANTIZE, 6'd21, 16'h0000, 16'hAAAA, 16'h5555, 4'h5);
        send_beat(OP_QUANTIZE, 6'd42, 16'hFFFF, 16'h5555, 16'hAAAA, 4'hA);
        send_beat(OP_QUANTIZE, 6'd7,  16'h0001, 16'h1234, 16'h4321, 4'h3);
        // load then quantize the same position back to back; result wraps
        send_beat(OP_LOAD,     6'd5,  16'h0000, 16'hFFFF, 16'h8000, 4'h0);
        send_beat(OP_QUANTIZE, 6'd5,  16'h7FFF, 16'h0000, 16'h0000, 4'h0);

        // random traffic under each idling pattern
        run_phase(300, 0, 0);
        run_phase(300, 58, 0);
        run_phase(300, 0, 58);
        run_phase(300, 16, 16);

        // receiver holds off while the sender keeps pushing
        hold_pending = 1'b1;
        run_phase(150, 0, 0);

        // sender pauses until everything has drained
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);

        run_phase(150, 16, 16);

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && outstanding == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
